// File: src/emare_pkg.sv
// Shared constants, types and helper functions of the EMA rate estimator.
package emare_pkg;

  // Fixed-point format of both averages: unsigned, FRACTION_BITS fraction bits in AVG_W bits.
  localparam int FRACTION_BITS = 16;
  localparam int AVG_W         = 48;
  localparam int INT_W         = AVG_W - FRACTION_BITS;
  localparam int ALPHA_W       = 16;
  localparam int STAMP_W       = 64;
  localparam int VALUE_W       = 32;
  localparam int AGE_W         = 40;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 40;

  // Shared multiplier: one half of a 48-bit operand by a 32-bit operand.
  localparam int HALF_W        = AVG_W / 2;
  localparam int MUL_B_W       = 32;
  localparam int PROD_W        = HALF_W + MUL_B_W;
  localparam int ACC_W         = PROD_W + HALF_W;

  // Serial divider.
  localparam int DIV_STEPS     = ACC_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  localparam logic [AVG_W-1:0]   AVG_MAX      = {AVG_W{1'b1}};
  localparam logic [MUL_B_W-1:0] NS_PER_SEC   = 32'd1_000_000_000;
  localparam logic [STAMP_W-1:0] FIRST_GAP_NS = 64'd5_000_000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 16'd3277;
  localparam logic [AGE_W-1:0]   AGE_RESET    = 40'd1_000_000_000;

  // Item modes.
  localparam logic [1:0] MODE_UPDATE = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_PRESET = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE   = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_WAIT,
    S_APPLY,
    S_RATE_LO,
    S_RATE_HI,
    S_RATE_WAIT,
    S_DIV_START,
    S_DIV_RUN,
    S_WB
  } state_t;

  // Command to the shared multiply-accumulate unit.
  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic hi_half;
  } mac_cmd_t;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Scale an integer into the average format, saturating at the top.
  function automatic logic [AVG_W-1:0] to_q(input logic [STAMP_W-1:0] x);
    logic [AVG_W-1:0] r;
    if (|x[STAMP_W-1:INT_W]) begin
      r = AVG_MAX;
    end else begin
      r = {x[INT_W-1:0], {FRACTION_BITS{1'b0}}};
    end
    return r;
  endfunction

endpackage

// File: src/emare_mac.sv
// Shared multiply-accumulate unit: half-word products summed into a wide accumulator.
module emare_mac (
  input  logic                        clk,
  input  logic                        rst_n,
  input  emare_pkg::mac_cmd_t         cmd,
  input  logic [emare_pkg::HALF_W-1:0]  op_a,
  input  logic [emare_pkg::MUL_B_W-1:0] op_b,
  output logic [emare_pkg::ACC_W-1:0]   acc
);

  logic [emare_pkg::PROD_W-1:0] prod_r;
  logic                         pend_r;
  logic                         hi_r;
  logic [emare_pkg::ACC_W-1:0]  acc_r;
  logic [emare_pkg::ACC_W-1:0]  addend;

  // The product is registered; it joins the accumulator in the following cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      hi_r   <= 1'b0;
    end else begin
      pend_r <= cmd.mul_en;
      hi_r   <= cmd.hi_half;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= op_a * op_b;
    end
  end

  // The upper half's product is weighted by the half width.
  always_comb begin
    if (hi_r) begin
      addend = {prod_r, {emare_pkg::HALF_W{1'b0}}};
    end else begin
      addend = {{emare_pkg::HALF_W{1'b0}}, prod_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (pend_r) begin
      acc_r <= acc_r + addend;
    end
  end

  assign acc = acc_r;

endmodule

// File: src/emare_div.sv
// Restoring serial divider, one quotient bit a cycle, with a saturating quotient.
module emare_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [emare_pkg::ACC_W-1:0]   dividend,
  input  logic [emare_pkg::AVG_W-1:0]   divisor,
  output emare_pkg::div_stat_t          stat,
  output logic [emare_pkg::AVG_W-1:0]   quotient
);

  logic [emare_pkg::ACC_W-1:0]     dvd_r;
  logic [emare_pkg::AVG_W-1:0]     dsr_r;
  logic [emare_pkg::AVG_W-1:0]     rem_r;
  logic [emare_pkg::AVG_W-1:0]     quo_r;
  logic                            sat_r;
  logic [emare_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic [emare_pkg::AVG_W:0]       rem_sh;
  logic                            fits;

  // Bring down the next dividend bit and try the subtraction.
  assign rem_sh = {rem_r, dvd_r[emare_pkg::ACC_W-1]};
  assign fits   = (rem_sh >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == emare_pkg::DIV_CNT_W'(emare_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // A quotient bit shifted out of the top means the result saturates.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
      sat_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[emare_pkg::ACC_W-2:0], 1'b0};
      if (fits) begin
        rem_r <= emare_pkg::AVG_W'(rem_sh - {1'b0, dsr_r});
      end else begin
        rem_r <= rem_sh[emare_pkg::AVG_W-1:0];
      end
      quo_r <= {quo_r[emare_pkg::AVG_W-2:0], fits};
      sat_r <= sat_r | quo_r[emare_pkg::AVG_W-1];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = sat_r ? emare_pkg::AVG_MAX : quo_r;

endmodule

// File: src/ema_rate_estimator.sv
// Top level of the EMA rate estimator: sequencer, state registers and result register.
//
// Each update item steps the value and gap averages and each preset item loads them;
// every item returns the rate average_value * 1e9 / average_gap (zero while the gap
// average is zero), plus a copy that reads zero once the last sample is at least
// max_sample_age ns old. One item is worked on at a time and in_stall is high until
// its result is in the output register. The 80-step serial divider runs for every
// item with a nonzero gap average, after the shared 24x32 multiplier, used twice per
// average and twice for the scaling by one second. A result waiting on out_stall does
// not block the next input transfer.
module ema_rate_estimator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_mode,
  input  logic [emare_pkg::VALUE_W-1:0]     in_sample_value,
  input  logic [emare_pkg::STAMP_W-1:0]     in_timestamp,
  input  logic [emare_pkg::VALUE_W-1:0]     in_preset_interval,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [emare_pkg::AVG_W-1:0]       out_rate_plain,
  output logic [emare_pkg::AVG_W-1:0]       out_rate_fresh,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [emare_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [emare_pkg::CFG_DATA_W-1:0]  cfg_data
);

  emare_pkg::state_t state_r, state_nxt;

  logic [emare_pkg::ALPHA_W-1:0] alpha_r;
  logic [emare_pkg::AGE_W-1:0]   max_age_r;

  logic [emare_pkg::AVG_W-1:0]   avg_val_r, avg_val_nxt;
  logic [emare_pkg::AVG_W-1:0]   avg_gap_r, avg_gap_nxt;
  logic [emare_pkg::STAMP_W-1:0] last_r, last_nxt;
  logic                          has_r, has_nxt;

  logic [emare_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic [emare_pkg::STAMP_W-1:0] ts_r, ts_nxt;
  logic [emare_pkg::STAMP_W-1:0] gap_raw_r, gap_raw_nxt;
  logic                          which_r, which_nxt;
  logic [emare_pkg::AVG_W-1:0]   diff_r, diff_nxt;
  logic                          up_r, up_nxt;
  logic                          stale_r, stale_nxt;
  logic [emare_pkg::AVG_W-1:0]   rate_r, rate_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [emare_pkg::AVG_W-1:0]   out_plain_r, out_plain_nxt;
  logic [emare_pkg::AVG_W-1:0]   out_fresh_r, out_fresh_nxt;

  logic                          in_xfer;
  logic                          out_xfer;
  logic                          slot_free;
  logic [emare_pkg::AVG_W-1:0]   obs;
  logic [emare_pkg::AVG_W-1:0]   cur;
  logic [emare_pkg::AVG_W-1:0]   step;
  logic [emare_pkg::AVG_W-1:0]   ema_new;
  logic [emare_pkg::STAMP_W-1:0] elapsed;

  emare_pkg::mac_cmd_t           mac_cmd;
  logic [emare_pkg::HALF_W-1:0]  mac_a;
  logic [emare_pkg::MUL_B_W-1:0] mac_b;
  logic [emare_pkg::ACC_W-1:0]   mac_acc;

  logic                          div_start;
  emare_pkg::div_stat_t          div_stat;
  logic [emare_pkg::AVG_W-1:0]   div_quo;

  emare_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mac_cmd),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .acc   (mac_acc)
  );

  emare_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mac_acc),
    .divisor  (avg_gap_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // Handshakes.
  assign in_stall  = (state_r != emare_pkg::S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r   <= emare_pkg::ALPHA_RESET;
      max_age_r <= emare_pkg::AGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        emare_pkg::CFG_SMOOTHING: alpha_r   <= cfg_data[emare_pkg::ALPHA_W-1:0];
        emare_pkg::CFG_MAX_AGE:   max_age_r <= cfg_data[emare_pkg::AGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Observation and current average of whichever average is being stepped.
  always_comb begin
    if (which_r) begin
      obs = emare_pkg::to_q(gap_raw_r);
      cur = avg_gap_r;
    end else begin
      obs = emare_pkg::to_q({{(emare_pkg::STAMP_W-emare_pkg::VALUE_W){1'b0}}, val_r});
      cur = avg_val_r;
    end
  end

  // The step is alpha * |obs - avg| with the 16 fraction bits of alpha dropped.
  assign step    = mac_acc[emare_pkg::ALPHA_W +: emare_pkg::AVG_W];
  assign ema_new = up_r ? (cur + step) : (cur - step);
  assign elapsed = ts_r - last_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      emare_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_mode == emare_pkg::MODE_UPDATE) begin
            state_nxt = emare_pkg::S_DIFF;
          end else begin
            state_nxt = emare_pkg::S_RATE_LO;
          end
        end
      end
      emare_pkg::S_DIFF:      state_nxt = emare_pkg::S_MUL_LO;
      emare_pkg::S_MUL_LO:    state_nxt = emare_pkg::S_MUL_HI;
      emare_pkg::S_MUL_HI:    state_nxt = emare_pkg::S_MUL_WAIT;
      emare_pkg::S_MUL_WAIT:  state_nxt = emare_pkg::S_APPLY;
      emare_pkg::S_APPLY: begin
        if (which_r) begin
          state_nxt = emare_pkg::S_RATE_LO;
        end else begin
          state_nxt = emare_pkg::S_DIFF;
        end
      end
      emare_pkg::S_RATE_LO:   state_nxt = emare_pkg::S_RATE_HI;
      emare_pkg::S_RATE_HI:   state_nxt = emare_pkg::S_RATE_WAIT;
      emare_pkg::S_RATE_WAIT: state_nxt = emare_pkg::S_DIV_START;
      emare_pkg::S_DIV_START: begin
        if (avg_gap_r == '0) begin
          state_nxt = emare_pkg::S_WB;
        end else begin
          state_nxt = emare_pkg::S_DIV_RUN;
        end
      end
      emare_pkg::S_DIV_RUN: begin
        if (div_stat.done) begin
          state_nxt = emare_pkg::S_WB;
        end
      end
      emare_pkg::S_WB: begin
        if (slot_free) begin
          state_nxt = emare_pkg::S_IDLE;
        end
      end
      default: state_nxt = emare_pkg::S_IDLE;
    endcase
  end

  // Datapath updates and unit commands for each step of the sequence.
  always_comb begin
    avg_val_nxt   = avg_val_r;
    avg_gap_nxt   = avg_gap_r;
    last_nxt      = last_r;
    has_nxt       = has_r;
    val_nxt       = val_r;
    ts_nxt        = ts_r;
    gap_raw_nxt   = gap_raw_r;
    which_nxt     = which_r;
    diff_nxt      = diff_r;
    up_nxt        = up_r;
    stale_nxt     = stale_r;
    rate_nxt      = rate_r;
    out_plain_nxt = out_plain_r;
    out_fresh_nxt = out_fresh_r;
    out_valid_nxt = out_xfer ? 1'b0 : out_valid_r;
    mac_cmd       = '0;
    mac_a         = '0;
    mac_b         = '0;
    div_start     = 1'b0;
    case (state_r)
      emare_pkg::S_IDLE: begin
        if (in_xfer) begin
          val_nxt   = in_sample_value;
          ts_nxt    = in_timestamp;
          which_nxt = 1'b0;
          // Before the first sample the gap is taken as 5 ms.
          gap_raw_nxt = has_r ? (in_timestamp - last_r) : emare_pkg::FIRST_GAP_NS;
          if (in_mode == emare_pkg::MODE_PRESET) begin
            avg_val_nxt = emare_pkg::to_q(
              {{(emare_pkg::STAMP_W-emare_pkg::VALUE_W){1'b0}}, in_sample_value});
            avg_gap_nxt = emare_pkg::to_q(
              {{(emare_pkg::STAMP_W-emare_pkg::VALUE_W){1'b0}}, in_preset_interval});
          end
        end
      end
      emare_pkg::S_DIFF: begin
        up_nxt = (obs >= cur);
        if (obs >= cur) begin
          diff_nxt = obs - cur;
        end else begin
          diff_nxt = cur - obs;
        end
      end
      emare_pkg::S_MUL_LO: begin
        mac_cmd.mul_en  = 1'b1;
        mac_cmd.acc_clr = 1'b1;
        mac_a = diff_r[emare_pkg::HALF_W-1:0];
        mac_b = {{(emare_pkg::MUL_B_W-emare_pkg::ALPHA_W){1'b0}}, alpha_r};
      end
      emare_pkg::S_MUL_HI: begin
        mac_cmd.mul_en  = 1'b1;
        mac_cmd.hi_half = 1'b1;
        mac_a = diff_r[emare_pkg::AVG_W-1:emare_pkg::HALF_W];
        mac_b = {{(emare_pkg::MUL_B_W-emare_pkg::ALPHA_W){1'b0}}, alpha_r};
      end
      emare_pkg::S_APPLY: begin
        if (which_r) begin
          avg_gap_nxt = ema_new;
          last_nxt    = ts_r;
          has_nxt     = 1'b1;
        end else begin
          avg_val_nxt = ema_new;
          which_nxt   = 1'b1;
        end
      end
      emare_pkg::S_RATE_LO: begin
        mac_cmd.mul_en  = 1'b1;
        mac_cmd.acc_clr = 1'b1;
        mac_a = avg_val_r[emare_pkg::HALF_W-1:0];
        mac_b = emare_pkg::NS_PER_SEC;
        // Wrap-safe age test: a timestamp before the last sample is never stale.
        stale_nxt = !elapsed[emare_pkg::STAMP_W-1] &&
                    (elapsed >= {{(emare_pkg::STAMP_W-emare_pkg::AGE_W){1'b0}}, max_age_r});
      end
      emare_pkg::S_RATE_HI: begin
        mac_cmd.mul_en  = 1'b1;
        mac_cmd.hi_half = 1'b1;
        mac_a = avg_val_r[emare_pkg::AVG_W-1:emare_pkg::HALF_W];
        mac_b = emare_pkg::NS_PER_SEC;
      end
      emare_pkg::S_DIV_START: begin
        if (avg_gap_r == '0) begin
          rate_nxt = '0;
        end else begin
          div_start = 1'b1;
        end
      end
      emare_pkg::S_DIV_RUN: begin
        if (div_stat.done) begin
          rate_nxt = div_quo;
        end
      end
      emare_pkg::S_WB: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_plain_nxt = rate_r;
          out_fresh_nxt = stale_r ? '0 : rate_r;
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= emare_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      avg_val_r   <= '0;
      avg_gap_r   <= '0;
      last_r      <= '0;
      has_r       <= 1'b0;
      which_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      avg_val_r   <= avg_val_nxt;
      avg_gap_r   <= avg_gap_nxt;
      last_r      <= last_nxt;
      has_r       <= has_nxt;
      which_r     <= which_nxt;
    end
  end

  // Working registers of the item in flight and the result register.
  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    ts_r        <= ts_nxt;
    gap_raw_r   <= gap_raw_nxt;
    diff_r      <= diff_nxt;
    up_r        <= up_nxt;
    stale_r     <= stale_nxt;
    rate_r      <= rate_nxt;
    out_plain_r <= out_plain_nxt;
    out_fresh_r <= out_fresh_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_rate_plain = out_plain_r;
  assign out_rate_fresh = out_fresh_r;

endmodule

// File: tb/sv/ema_rate_estimator_tb.sv
// Self-checking testbench of the EMA rate estimator, with a scoreboard that predicts every result.
module ema_rate_estimator_tb;

  // Mode code that the block treats as a query.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  // Register index with no register behind it.
  localparam logic [emare_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [emare_pkg::AVG_W-1:0] INT_MAX_Q =
    emare_pkg::AVG_MAX >> emare_pkg::FRACTION_BITS;
  localparam int QUIET_LIMIT     = 5000;
  localparam int TAIL_CYCLES     = 200;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 235;

  typedef struct packed {
    logic [emare_pkg::AVG_W-1:0] plain;
    logic [emare_pkg::AVG_W-1:0] fresh;
  } rate_pair_t;

  // Tracks the averages and settings of the block and holds the rates still to come out.
  class rate_scoreboard;
    logic [emare_pkg::ALPHA_W-1:0] alpha;
    logic [emare_pkg::AGE_W-1:0]   age_limit;
    logic [emare_pkg::AVG_W-1:0]   avg_value;
    logic [emare_pkg::AVG_W-1:0]   avg_gap;
    logic [emare_pkg::STAMP_W-1:0] last_stamp;
    bit                            seen_sample;
    rate_pair_t                    pending_rates[$];
    int                            errors;

    function new();
      alpha       = emare_pkg::ALPHA_RESET;
      age_limit   = emare_pkg::AGE_RESET;
      avg_value   = '0;
      avg_gap     = '0;
      last_stamp  = '0;
      seen_sample = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(logic [emare_pkg::CFG_IDX_W-1:0] idx,
                            logic [emare_pkg::CFG_DATA_W-1:0] data);
      if (idx == emare_pkg::CFG_SMOOTHING) begin
        alpha = data[emare_pkg::ALPHA_W-1:0];
      end else if (idx == emare_pkg::CFG_MAX_AGE) begin
        age_limit = data[emare_pkg::AGE_W-1:0];
      end
    endfunction

    // Integer into the average format, clipped at the largest code.
    function logic [emare_pkg::AVG_W-1:0] scale_int(logic [emare_pkg::STAMP_W-1:0] x);
      logic [emare_pkg::STAMP_W-1:0] shifted;
      if (x > {16'd0, INT_MAX_Q}) return emare_pkg::AVG_MAX;
      shifted = x << emare_pkg::FRACTION_BITS;
      return shifted[emare_pkg::AVG_W-1:0];
    endfunction

    // Moves an average toward an observation; the step is truncated toward zero.
    function logic [emare_pkg::AVG_W-1:0] ema_toward(logic [emare_pkg::AVG_W-1:0] avg,
                                                     logic [emare_pkg::AVG_W-1:0] obs);
      logic [63:0] diff;
      logic [63:0] step;
      if (obs >= avg) diff = {16'd0, obs - avg};
      else diff = {16'd0, avg - obs};
      step = (diff * {48'd0, alpha}) >> emare_pkg::ALPHA_W;
      if (obs >= avg) return avg + step[emare_pkg::AVG_W-1:0];
      return avg - step[emare_pkg::AVG_W-1:0];
    endfunction

    // Average value per second, clipped; zero while the gap average is zero.
    function logic [emare_pkg::AVG_W-1:0] current_rate();
      logic [127:0] scaled;
      logic [127:0] quo;
      if (avg_gap == '0) return '0;
      scaled = {80'd0, avg_value} * {96'd0, emare_pkg::NS_PER_SEC};
      quo    = scaled / {80'd0, avg_gap};
      if (quo > {80'd0, emare_pkg::AVG_MAX}) return emare_pkg::AVG_MAX;
      return quo[emare_pkg::AVG_W-1:0];
    endfunction

    function void note_item(logic [1:0] mode, logic [emare_pkg::VALUE_W-1:0] value,
                            logic [emare_pkg::STAMP_W-1:0] stamp,
                            logic [emare_pkg::VALUE_W-1:0] interval);
      logic [emare_pkg::STAMP_W-1:0] prev;
      logic [emare_pkg::STAMP_W-1:0] elapsed;
      logic [emare_pkg::AVG_W-1:0]   rate;
      bit                            stale;
      rate_pair_t                    due;
      if (mode == emare_pkg::MODE_UPDATE) begin
        // The very first sample is taken as 5 ms after an imaginary one.
        prev        = seen_sample ? last_stamp : stamp - emare_pkg::FIRST_GAP_NS;
        avg_value   = ema_toward(avg_value, scale_int({32'd0, value}));
        avg_gap     = ema_toward(avg_gap, scale_int(stamp - prev));
        last_stamp  = stamp;
        seen_sample = 1'b1;
      end else if (mode == emare_pkg::MODE_PRESET) begin
        avg_value = scale_int({32'd0, value});
        avg_gap   = scale_int({32'd0, interval});
      end
      rate = current_rate();
      // A stamp behind the last sample reads as negative and is never stale.
      elapsed   = stamp - last_stamp;
      stale     = !elapsed[emare_pkg::STAMP_W-1] && (elapsed >= {24'd0, age_limit});
      due.plain = rate;
      due.fresh = stale ? '0 : rate;
      pending_rates.push_back(due);
    endfunction

    function void check_result(logic [emare_pkg::AVG_W-1:0] plain,
                               logic [emare_pkg::AVG_W-1:0] fresh);
      rate_pair_t due;
      if (pending_rates.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding, plain %0d fresh %0d",
                 $time, plain, fresh);
        return;
      end
      due = pending_rates.pop_front();
      if (plain !== due.plain) begin
        errors++;
        $display("%0t: rate_plain mismatch, expected %0d, actual %0d",
                 $time, due.plain, plain);
      end
      if (fresh !== due.fresh) begin
        errors++;
        $display("%0t: rate_fresh mismatch, expected %0d, actual %0d",
                 $time, due.fresh, fresh);
      end
    endfunction

    function int outstanding();
      return pending_rates.size();
    endfunction

    function void report_leftover();
      if (pending_rates.size() != 0) begin
        errors++;
        $display("%0t: %0d results never arrived", $time, pending_rates.size());
      end
    endfunction
  endclass

  logic                             clk                = 1'b0;
  logic                             rst_n              = 1'b0;
  logic                             in_valid           = 1'b0;
  logic                             in_stall;
  logic [1:0]                       in_mode            = emare_pkg::MODE_QUERY;
  logic [emare_pkg::VALUE_W-1:0]    in_sample_value    = '0;
  logic [emare_pkg::STAMP_W-1:0]    in_timestamp       = '0;
  logic [emare_pkg::VALUE_W-1:0]    in_preset_interval = '0;
  logic                             out_valid;
  logic                             out_stall          = 1'b0;
  logic [emare_pkg::AVG_W-1:0]      out_rate_plain;
  logic [emare_pkg::AVG_W-1:0]      out_rate_fresh;
  logic                             cfg_valid          = 1'b0;
  logic                             cfg_ready;
  logic [emare_pkg::CFG_IDX_W-1:0]  cfg_index          = emare_pkg::CFG_SMOOTHING;
  logic [emare_pkg::CFG_DATA_W-1:0] cfg_data           = '0;

  rate_scoreboard book = new();
  bit             calm = 1'b0;

  ema_rate_estimator i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_sample_value    (in_sample_value),
    .in_timestamp       (in_timestamp),
    .in_preset_interval (in_preset_interval),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_rate_plain     (out_rate_plain),
    .out_rate_fresh     (out_rate_fresh),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [emare_pkg::VALUE_W-1:0] random_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return $urandom_range(0, 5000);
    if (roll < 8) return $urandom;
    if (roll == 8) return '0;
    return '1;
  endfunction

  // Time since the last sample: packet-like steps, long ones, the age edge, backwards, anything.
  function automatic logic [emare_pkg::STAMP_W-1:0] next_step();
    int     roll;
    longint off;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 64'($urandom_range(1, 20_000_000));
    if (roll < 75) return {32'd0, $urandom};
    if (roll < 88) begin
      off = $urandom_range(0, 4);
      off = off - 2;
      return {24'd0, book.age_limit} + off;
    end
    if (roll < 95) return 64'd0 - 64'($urandom_range(1, 1000));
    return {$urandom, $urandom};
  endfunction

  // Result side: checks every transfer and stalls at random.
  always @(posedge clk) begin : result_side
    int next_gap;
    if (rst_n && out_valid && !out_stall) begin
      book.check_result(out_rate_plain, out_rate_fresh);
    end
    if (rst_n && book.outstanding() == 0 && !out_valid) begin
      next_gap = 0;
    end
    if (next_gap > 0) begin
      next_gap  = next_gap - 1;
      out_stall <= 1'b1;
    end else begin
      next_gap  = pick_gap();
      out_stall <= (next_gap > 0);
      if (next_gap > 0) next_gap = next_gap - 1;
    end
  end

  // Ends the run when no transfer of any kind has happened for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Offers one item after a random gap and returns at the edge where it is taken.
  task automatic send_item(input logic [1:0] mode,
                           input logic [emare_pkg::VALUE_W-1:0] value,
                           input logic [emare_pkg::STAMP_W-1:0] stamp,
                           input logic [emare_pkg::VALUE_W-1:0] interval);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_mode            <= mode;
    in_sample_value    <= value;
    in_timestamp       <= stamp;
    in_preset_interval <= interval;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_item(mode, value, stamp, interval);
  endtask

  // Holds the sender back until every outstanding result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (book.outstanding() != 0) @(posedge clk);
  endtask

  // Writes both registers, and the unused index when asked; only called while idle.
  task automatic configure(input logic [emare_pkg::CFG_DATA_W-1:0] alpha_word,
                           input logic [emare_pkg::CFG_DATA_W-1:0] age_word,
                           input bit poke_unused);
    logic [emare_pkg::CFG_IDX_W-1:0]  idx[$];
    logic [emare_pkg::CFG_DATA_W-1:0] dat[$];
    idx.push_back(emare_pkg::CFG_SMOOTHING);
    dat.push_back(alpha_word);
    idx.push_back(emare_pkg::CFG_MAX_AGE);
    dat.push_back(age_word);
    if (poke_unused) begin
      idx.push_back(CFG_UNUSED);
      dat.push_back({8'($urandom_range(0, 255)), $urandom});
    end
    foreach (idx[k]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= dat[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      book.write_reg(idx[k], dat[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed updates and queries around the last sample, some presets and noise.
  task automatic random_item();
    int                            roll;
    logic [1:0]                    mode;
    logic [emare_pkg::VALUE_W-1:0] value;
    logic [emare_pkg::VALUE_W-1:0] interval;
    logic [emare_pkg::STAMP_W-1:0] stamp;
    roll     = $urandom_range(0, 99);
    value    = random_value();
    interval = $urandom;
    stamp    = book.last_stamp + next_step();
    if (roll < 55) begin
      mode = emare_pkg::MODE_UPDATE;
    end else if (roll < 80) begin
      mode = emare_pkg::MODE_QUERY;
    end else if (roll < 92) begin
      mode = emare_pkg::MODE_PRESET;
      roll = $urandom_range(0, 9);
      if (roll < 3) interval = $urandom_range(1, 5_000_000);
      else if (roll == 3) interval = '0;
    end else begin
      mode     = 2'($urandom_range(0, 3));
      value    = $urandom;
      stamp    = {$urandom, $urandom};
      interval = $urandom;
    end
    send_item(mode, value, stamp, interval);
  endtask

  initial begin : stimulus
    logic [emare_pkg::CFG_DATA_W-1:0] alpha_word;
    logic [emare_pkg::CFG_DATA_W-1:0] age_word;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Before any sample, with a zero gap average, and with a stamp far behind.
    send_item(emare_pkg::MODE_QUERY, '0, '0, '0);
    send_item(emare_pkg::MODE_QUERY, '1, '1, '1);
    send_item(emare_pkg::MODE_PRESET, '0, 64'd100, '0);
    // First sample, then a normal one.
    send_item(emare_pkg::MODE_UPDATE, '1, 64'd1_000_000_000, '0);
    send_item(emare_pkg::MODE_UPDATE, '0, 64'd1_001_000_000, '1);
    // Age just under the limit, exactly at it, and behind the last sample.
    send_item(emare_pkg::MODE_QUERY, 32'd7,
              book.last_stamp + {24'd0, book.age_limit} - 64'd1, '0);
    send_item(emare_pkg::MODE_QUERY, 32'd7, book.last_stamp + {24'd0, book.age_limit}, '0);
    send_item(emare_pkg::MODE_QUERY, 32'd7, book.last_stamp - 64'd1, '0);
    // Presets that clip the rate and that make it tiny.
    send_item(emare_pkg::MODE_PRESET, '1, book.last_stamp, 32'd1);
    send_item(emare_pkg::MODE_PRESET, 32'd1, book.last_stamp, '1);
    send_item(MODE_SPARE, $urandom, book.last_stamp + 64'd5, $urandom);
    // A gap too large for the average format, then one across the wrap of the counter.
    send_item(emare_pkg::MODE_UPDATE, 32'd1000, 64'hFFFF_FFFF_FFFF_FFF0, '0);
    send_item(emare_pkg::MODE_UPDATE, 32'd1000, 64'd16, '0);
    send_item(emare_pkg::MODE_UPDATE, 32'd50, 64'h8000_0000_0000_0000, '0);
    send_item(emare_pkg::MODE_QUERY, '0, 64'd0, '0);
    drain();

    // Zero weight freezes the averages; a zero age limit makes every stamp at or after the last sample stale.
    configure('0, '0, 1'b0);
    send_item(emare_pkg::MODE_UPDATE, '1, book.last_stamp + 64'd2_000_000, '0);
    send_item(emare_pkg::MODE_QUERY, '0, book.last_stamp, '0);
    drain();

    // Full weight and the largest age limit.
    configure({24'd0, 16'hFFFF}, '1, 1'b0);
    send_item(emare_pkg::MODE_UPDATE, 32'd123456, book.last_stamp + 64'd3_000_000, '0);
    send_item(emare_pkg::MODE_QUERY, '0, book.last_stamp + 64'h00FF_FFFF_FFFE, '0);
    send_item(emare_pkg::MODE_QUERY, '0, book.last_stamp + 64'h00FF_FFFF_FFFF, '0);
    drain();

    // Random phases, each with its settings written first; one phase runs without idling.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          alpha_word = {24'd0, emare_pkg::ALPHA_RESET};
          age_word   = emare_pkg::AGE_RESET;
        end
        1: begin
          alpha_word = '0;
          age_word   = '0;
        end
        2: begin
          alpha_word = {24'd0, 16'hFFFF};
          age_word   = '1;
        end
        3: begin
          alpha_word = 40'd32768;
          age_word   = 40'd20_000_000;
        end
        4: begin
          alpha_word = {8'($urandom_range(0, 255)), $urandom};
          age_word   = {8'($urandom_range(0, 255)), $urandom};
        end
        5: begin
          alpha_word = 40'd1;
          age_word   = 40'd5_000_000;
        end
        6: begin
          alpha_word = {8'($urandom_range(0, 255)), $urandom};
          age_word   = 40'd1;
        end
        default: begin
          alpha_word = {24'd0, emare_pkg::ALPHA_RESET};
          age_word   = emare_pkg::AGE_RESET;
        end
      endcase
      calm = (phase == 3);
      configure(alpha_word, age_word, phase == 4);
      repeat (ITEMS_PER_PHASE) random_item();
      drain();
    end
    calm = 1'b0;

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    book.report_leftover();
    if (book.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
